@@ design/cfpr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfpr_pkg
// Shared types and constants for the colour frame pyramid reducer.
// ----------------------------------------------------------------------------
package cfpr_pkg;

  localparam int COARSEST_FRAMES_DEF = 256;
  localparam int MAX_LEVELS_DEF      = 16;

  localparam int LEVEL_W = 4;   // level index on the output
  localparam int LVCNT_W = 5;   // level count, up to 16
  localparam int COUNT_W = 24;  // frame counters

  localparam logic [7:0] HUE_HALF = 8'd128;  // half turn of hue

  // one colour frame, hue in the lowest byte
  typedef struct packed {
    logic [7:0] peak;
    logic [7:0] light;
    logic [7:0] sat;
    logic [7:0] hue;
  } frame_t;

  typedef struct packed {
    logic   start;
    frame_t a;
    frame_t b;
  } merge_req_t;

  typedef struct packed {
    logic   done;
    frame_t res;
  } merge_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_READ,
    S_MLOAD,
    S_MERGE
  } seq_state_t;

  typedef enum logic [1:0] {
    M_IDLE,
    M_DIV,
    M_FIN
  } mrg_state_t;

endpackage

@@ design/cfpr_pend_mem.sv @@
// ----------------------------------------------------------------------------
// cfpr_pend_mem
// Pending frame store, one entry per level below the coarsest, registered read.
// ----------------------------------------------------------------------------
module cfpr_pend_mem #(
  parameter int DEPTH = 15,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  cfpr_pkg::frame_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output cfpr_pkg::frame_t rd_data
);
  import cfpr_pkg::*;

  frame_t mem [DEPTH];

  // the sequencer never reads and writes in the same cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/cfpr_merge.sv @@
// ----------------------------------------------------------------------------
// cfpr_merge
// Merges two frames; hue step uses a bit-per-cycle floor divider.
// ----------------------------------------------------------------------------
module cfpr_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfpr_pkg::merge_req_t req,
  output cfpr_pkg::merge_rsp_t rsp
);
  import cfpr_pkg::*;

  mrg_state_t  state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [8:0]  q_r, q_nxt;
  logic [9:0]  den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic [7:0]  ah_r, ah_nxt;
  logic [7:0]  sav_r, sav_nxt;
  logic [7:0]  lav_r, lav_nxt;
  logic [7:0]  pk_r, pk_nxt;
  logic        done_r, done_nxt;
  frame_t      res_r, res_nxt;

  logic [7:0]         d;
  logic signed [9:0]  arc;
  logic [8:0]         w1, w2, tot;
  logic signed [19:0] prod, num;
  logic [18:0]        shifted;
  logic [8:0]         smag;
  logic [7:0]         hue_fin;

  always_comb begin
    d       = req.b.hue - req.a.hue + HUE_HALF;
    arc     = signed'({2'b00, d}) - signed'({2'b00, HUE_HALF});
    w1      = {1'b0, req.a.sat};
    w2      = {1'b0, req.b.sat};
    if (w1 + w2 == 9'd0) begin
      w1 = 9'd1;
      w2 = 9'd1;
    end
    tot     = w1 + w2;
    prod    = 20'(arc * signed'({1'b0, w2}));
    num     = (prod <<< 1) + signed'({11'd0, tot});
    shifted = 19'(den_r) << cnt_r;
    smag    = q_r + {8'd0, (rem_r != 18'd0)};
    hue_fin = neg_r ? (ah_r - smag[7:0]) : (ah_r + q_r[7:0]);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    den_nxt   = den_r;
    neg_nxt   = neg_r;
    ah_nxt    = ah_r;
    sav_nxt   = sav_r;
    lav_nxt   = lav_r;
    pk_nxt    = pk_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    case (state_r)
      M_IDLE: begin
        if (req.start) begin
          pk_nxt = (req.a.peak > req.b.peak) ? req.a.peak : req.b.peak;
          if (req.a.light == 8'd0 && req.b.light == 8'd0) begin
            res_nxt  = '{peak: pk_nxt, light: 8'd0, sat: 8'd0, hue: 8'd0};
            done_nxt = 1'b1;
          end else if (req.a.light == 8'd0) begin
            res_nxt      = req.b;
            res_nxt.peak = pk_nxt;
            done_nxt     = 1'b1;
          end else if (req.b.light == 8'd0) begin
            res_nxt      = req.a;
            res_nxt.peak = pk_nxt;
            done_nxt     = 1'b1;
          end else begin
            ah_nxt    = req.a.hue;
            sav_nxt   = 8'(({1'b0, req.a.sat} + {1'b0, req.b.sat} + 9'd1) >> 1);
            lav_nxt   = 8'(({1'b0, req.a.light} + {1'b0, req.b.light} + 9'd1) >> 1);
            neg_nxt   = num[19];
            rem_nxt   = num[19] ? 18'(-num) : 18'(num);
            den_nxt   = {tot, 1'b0};
            q_nxt     = '0;
            cnt_nxt   = 4'd8;
            state_nxt = M_DIV;
          end
        end
      end
      M_DIV: begin
        if ({1'b0, rem_r} >= shifted) begin
          rem_nxt       = 18'({1'b0, rem_r} - shifted);
          q_nxt[cnt_r]  = 1'b1;
        end
        if (cnt_r == 4'd0) begin
          state_nxt = M_FIN;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
        end
      end
      M_FIN: begin
        res_nxt   = '{peak: pk_r, light: lav_r, sat: sav_r, hue: hue_fin};
        done_nxt  = 1'b1;
        state_nxt = M_IDLE;
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    ah_r  <= ah_nxt;
    sav_r <= sav_nxt;
    lav_r <= lav_nxt;
    pk_r  <= pk_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

@@ design/colour_frame_pyramid_reducer.sv @@
// ----------------------------------------------------------------------------
// colour_frame_pyramid_reducer
// Emits each finest colour frame and folds neighbouring pairs into coarser
// pyramid levels, one pending frame per non-coarsest level held in a small memory.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  cfg     | in  | cfg_valid/cfg_ready   | cfg_data: finest frame count
//  in      | in  | in_tvalid/in_tready   | in_tdata: hue, sat, light, peak
//  out     | out | out_tvalid/out_tready | level, frame; tlast, tuser=done
//
// Sequence: the idle state takes the beat, then each beat is emitted; each
//   coarser level reads the pending memory when a partner waits (read, merge
//   load), then waits on the merge (quotient bits one per cycle, a finish
//   state and the result register). A silent merge skips the divider.
// One frame is in work at a time; in_tready is low until its last beat leaves.
// A cfg write wins over an input beat offered in the same cycle.
// A beat beyond the configured count is taken and dropped.
// Reset (rst_n, synchronous) clears control state and all pending valid bits;
//   the pending memory needs no clearing. A cfg write restarts the pyramid.
// out_tvalid holds with stable payload while out_tready is low.
// ----------------------------------------------------------------------------
module colour_frame_pyramid_reducer #(
  parameter int COARSEST_FRAMES = cfpr_pkg::COARSEST_FRAMES_DEF,
  parameter int MAX_LEVELS      = cfpr_pkg::MAX_LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,    // finest_frame_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // hue, saturation, lightness, peak
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // level_index[3:0], hue, saturation,
                                   // lightness, peak, 4 zero bits
  output logic        out_tlast,   // run_last
  output logic        out_tuser    // pyramid_done
);
  import cfpr_pkg::*;

  localparam int DEPTH = MAX_LEVELS - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  seq_state_t          state_r, state_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [COUNT_W-1:0]  seen_r, seen_nxt;
  logic                fin_r, fin_nxt;
  logic                last_r, last_nxt;
  logic [LVCNT_W-1:0]  levels_r, levels_nxt;
  logic [LEVEL_W-1:0]  lvl_r, lvl_nxt;
  logic [DEPTH-1:0]    pv_r, pv_nxt;
  frame_t              carry_r, carry_nxt;
  logic                tlast_r, tlast_nxt;
  logic                tuser_r, tuser_nxt;

  logic [LVCNT_W-1:0]  levels_cfg;
  logic                ignored, last_in;
  logic [LEVEL_W-1:0]  lvl_up;
  logic                pv_cur, pv_up, more_up, next0;
  frame_t              in_frame;

  logic                wr_en, rd_en;
  frame_t              rd_data;
  merge_req_t          mreq;
  merge_rsp_t          mrsp;

  assign in_frame = frame_t'(in_tdata);

  // level count: smallest k with count <= COARSEST_FRAMES * 2^k, plus one
  always_comb begin
    levels_cfg = LVCNT_W'(MAX_LEVELS);
    for (int k = MAX_LEVELS - 1; k >= 0; k--) begin
      if ({16'd0, cfg_data} <= (40'(COARSEST_FRAMES) << k)) begin
        levels_cfg = LVCNT_W'(k + 1);
      end
    end
  end

  // does a result follow the one at the current or the next level
  always_comb begin
    ignored  = fin_r || (seen_r >= count_r);
    last_in  = ((seen_r + COUNT_W'(1)) == count_r);
    lvl_up   = lvl_r + LEVEL_W'(1);
    pv_cur   = (int'(lvl_r) < DEPTH) ? pv_r[lvl_r[AW-1:0]] : 1'b0;
    pv_up    = (int'(lvl_up) < DEPTH) ? pv_r[lvl_up[AW-1:0]] : 1'b0;
    more_up  = (({1'b0, lvl_r} + LVCNT_W'(2)) < levels_r) && (pv_up || last_r);
    next0    = (levels_r > LVCNT_W'(1)) && (pv_r[0] || last_in);
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    seen_nxt   = seen_r;
    fin_nxt    = fin_r;
    last_nxt   = last_r;
    levels_nxt = levels_r;
    lvl_nxt    = lvl_r;
    pv_nxt     = pv_r;
    carry_nxt  = carry_r;
    tlast_nxt  = tlast_r;
    tuser_nxt  = tuser_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    mreq.start = 1'b0;
    mreq.a     = carry_r;
    mreq.b     = carry_r;
    in_tready  = (state_r == S_IDLE) && !cfg_valid;
    cfg_ready  = (state_r == S_IDLE);
    out_tvalid = (state_r == S_EMIT);
    case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          count_nxt  = cfg_data;
          levels_nxt = levels_cfg;
          seen_nxt   = '0;
          fin_nxt    = 1'b0;
          pv_nxt     = '0;
        end else if (in_tvalid && !ignored) begin
          seen_nxt  = seen_r + COUNT_W'(1);
          last_nxt  = last_in;
          fin_nxt   = last_in;
          lvl_nxt   = '0;
          carry_nxt = in_frame;
          tlast_nxt = !next0;
          tuser_nxt = !next0 && last_in;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_tready) begin
          if (tlast_r) begin
            // unpaired frame waits for its partner
            if (({1'b0, lvl_r} + LVCNT_W'(1)) < levels_r) begin
              wr_en                = 1'b1;
              pv_nxt[lvl_r[AW-1:0]] = 1'b1;
            end
            state_nxt = S_IDLE;
          end else if (pv_cur) begin
            pv_nxt[lvl_r[AW-1:0]] = 1'b0;
            state_nxt             = S_READ;
          end else begin
            mreq.start = 1'b1;  // last frame paired with itself
            state_nxt  = S_MERGE;
          end
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_MLOAD;
      end
      S_MLOAD: begin
        mreq.start = 1'b1;
        mreq.a     = rd_data;
        state_nxt  = S_MERGE;
      end
      S_MERGE: begin
        if (mrsp.done) begin
          carry_nxt = mrsp.res;
          lvl_nxt   = lvl_up;
          tlast_nxt = !more_up;
          tuser_nxt = !more_up && last_r;
          state_nxt = S_EMIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      seen_r   <= '0;
      fin_r    <= 1'b0;
      last_r   <= 1'b0;
      levels_r <= LVCNT_W'(1);
      lvl_r    <= '0;
      pv_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      seen_r   <= seen_nxt;
      fin_r    <= fin_nxt;
      last_r   <= last_nxt;
      levels_r <= levels_nxt;
      lvl_r    <= lvl_nxt;
      pv_r     <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    tlast_r <= tlast_nxt;
    tuser_r <= tuser_nxt;
  end

  cfpr_pend_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (lvl_r[AW-1:0]),
    .wr_data (carry_r),
    .rd_en   (rd_en),
    .rd_addr (lvl_r[AW-1:0]),
    .rd_data (rd_data)
  );

  cfpr_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign out_tdata = {4'd0, carry_r, lvl_r};
  assign out_tlast = tlast_r;
  assign out_tuser = tuser_r;

  // no input taken while a result beat is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input ready during output beat");

  // a non-final beat always has a coarser level behind it
  a_more_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |->
      (({1'b0, lvl_r} + LVCNT_W'(1)) < levels_r)) else $error("level overrun");

  // done only on the final beat of the run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast) else $error("done without last");

  // once finished, every frame of the count has been seen
  a_fin_count: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> (seen_r == count_r)) else $error("finished early");

  // a merge result only arrives while the sequencer waits for it
  a_merge_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> (state_r == S_MERGE)) else $error("stray merge result");

endmodule

@@ test/pyramid_checker.sv @@
// ----------------------------------------------------------------------------
// pyramid_checker
// Watches the cfg, in and out channels of the pyramid reducer. It keeps its
// own copy of the per-level pending frames and predicts every out beat.
// Each out beat is then compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pyramid_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [23:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  output int          due_count,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import cfpr_pkg::*;

  typedef struct {
    logic [3:0] level;
    frame_t     frm;
    logic       last;
    logic       done;
  } level_beat_t;

  level_beat_t   pyramid_frames_due[$];
  frame_t        held_frame[MAX_LEVELS_DEF-1];
  logic          held_valid[MAX_LEVELS_DEF-1];
  logic [23:0]   frame_total;
  logic [23:0]   frames_taken;
  logic          pyramid_closed;
  int            errors;

  // pair merge: larger peak, silent frames drop out, hue along shorter arc
  function automatic frame_t fold_pair(frame_t a, frame_t b);
    frame_t r;
    int arc, w1, w2, tot, num, den, stp;
    r.peak = (a.peak > b.peak) ? a.peak : b.peak;
    if (a.light == 8'd0 && b.light == 8'd0) begin
      r.hue = 8'd0; r.sat = 8'd0; r.light = 8'd0;
    end else if (a.light == 8'd0) begin
      r.hue = b.hue; r.sat = b.sat; r.light = b.light;
    end else if (b.light == 8'd0) begin
      r.hue = a.hue; r.sat = a.sat; r.light = a.light;
    end else begin
      arc = ((int'(b.hue) + 384 - int'(a.hue)) % 256) - 128;
      w1  = int'(a.sat);
      w2  = int'(b.sat);
      if (w1 + w2 == 0) begin
        w1 = 1;
        w2 = 1;
      end
      tot = w1 + w2;
      num = 2 * arc * w2 + tot;
      den = 2 * tot;
      stp = (num >= 0) ? num / den : -((-num + den - 1) / den);
      r.hue   = 8'((int'(a.hue) + stp + 256) % 256);
      r.sat   = 8'((int'(a.sat) + int'(b.sat) + 1) / 2);
      r.light = 8'((int'(a.light) + int'(b.light) + 1) / 2);
    end
    return r;
  endfunction

  function automatic int level_total(logic [23:0] cnt);
    int lv;
    int f;
    lv = 1;
    f  = int'(cnt);
    while (f > COARSEST_FRAMES_DEF && lv < MAX_LEVELS_DEF) begin
      f = (f + 1) / 2;
      lv++;
    end
    return lv;
  endfunction

  task automatic predict_frame(frame_t f);
    level_beat_t b;
    frame_t      carry;
    logic        have, last;
    int          levels;
    if (pyramid_closed || frames_taken >= frame_total) return;
    frames_taken = frames_taken + 24'd1;
    last   = (frames_taken == frame_total);
    levels = level_total(frame_total);
    carry  = f;
    have   = 1'b1;
    b = '{level: 4'd0, frm: carry, last: 1'b0, done: 1'b0};
    pyramid_frames_due = {pyramid_frames_due, b};
    for (int l = 0; l + 1 < levels && l < MAX_LEVELS_DEF - 1; l++) begin
      if (have) begin
        if (held_valid[l]) begin
          carry = fold_pair(held_frame[l], carry);
          held_valid[l] = 1'b0;
        end else if (last) begin
          carry = fold_pair(carry, carry);
        end else begin
          held_frame[l] = carry;
          held_valid[l] = 1'b1;
          have = 1'b0;
        end
      end else if (last && held_valid[l]) begin
        carry = fold_pair(held_frame[l], held_frame[l]);
        held_valid[l] = 1'b0;
        have = 1'b1;
      end
      if (!have) break;
      b = '{level: 4'(l + 1), frm: carry, last: 1'b0, done: 1'b0};
      pyramid_frames_due = {pyramid_frames_due, b};
    end
    pyramid_frames_due[$].last = 1'b1;
    if (last) begin
      pyramid_closed = 1'b1;
      pyramid_frames_due[$].done = 1'b1;
    end
  endtask

  task automatic check_beat();
    level_beat_t e;
    frame_t      got;
    logic [3:0]  lvl;
    got = out_tdata[35:4];
    lvl = out_tdata[3:0];
    if (pyramid_frames_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: out beat with nothing due: %h", $realtime, out_tdata);
      return;
    end
    e = pyramid_frames_due.pop_front();
    if (lvl !== e.level || got.hue !== e.frm.hue || got.sat !== e.frm.sat ||
        got.light !== e.frm.light || got.peak !== e.frm.peak ||
        out_tdata[39:36] !== 4'd0 || out_tlast !== e.last || out_tuser !== e.done) begin
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch exp lvl=%0d h=%0d s=%0d l=%0d p=%0d last=%b done=%b",
                 $realtime, e.level, e.frm.hue, e.frm.sat, e.frm.light, e.frm.peak,
                 e.last, e.done, "\n            got lvl=%0d h=%0d s=%0d l=%0d p=%0d",
                 lvl, got.hue, got.sat, got.light, got.peak,
                 " last=%b done=%b pad=%h", out_tlast, out_tuser, out_tdata[39:36]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_total    = '0;
      frames_taken   = '0;
      pyramid_closed = 1'b0;
      errors         = 0;
      for (int i = 0; i < MAX_LEVELS_DEF - 1; i++) held_valid[i] = 1'b0;
      pyramid_frames_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        frame_total    = cfg_data;
        frames_taken   = '0;
        pyramid_closed = 1'b0;
        for (int i = 0; i < MAX_LEVELS_DEF - 1; i++) held_valid[i] = 1'b0;
      end
      if (in_tvalid && in_tready) predict_frame(frame_t'(in_tdata));
      if (out_tvalid && out_tready) check_beat();
    end
    due_count  <= pyramid_frames_due.size();
    fail_count <= errors;
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the colour frame pyramid reducer: directed pair merges, short
// and full pyramids, ignored beats, then random frames under varying stalls.
// Checking lives in pyramid_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cfpr_pkg::*;

  localparam int IDLE_LIMIT  = 20000;  // cycles without any beat
  localparam int SETTLE_CYC  = 300;    // covers a 16 level cascade
  localparam int HOLD_CYC    = 400;    // long receiver hold-off

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // hue, saturation, lightness, peak
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // level[3:0], hue, sat, light, peak, pad
  logic        out_tlast;         // run_last
  logic        out_tuser;         // pyramid_done

  int due_count;
  int fail_count;
  int send_idle_pct = 0;          // % of cycles the sender skips
  int recv_idle_pct = 0;          // % of cycles the receiver stalls
  logic hold_req = 1'b0;          // asks for one long receiver hold-off
  logic holding = 1'b0;
  int idle_cycles = 0;

  always #6 clk = ~clk;

  colour_frame_pyramid_reducer dut (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
  );

  pyramid_checker chk (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser,
    .due_count, .fail_count
  );

  // receiver: random stalls, or a solid hold-off while holding
  always @(posedge clk) begin
    out_tready <= !holding && ($urandom_range(99) >= recv_idle_pct);
  end

  // long hold-off, counted here so the sender keeps offering beats meanwhile
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        holding <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        holding <= 1'b0;
      end
    end
  end

  // watchdog on beat activity of all channels
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic frame_t mk(int h, int s, int l, int p);
    frame_t f;
    f.hue = 8'(h); f.sat = 8'(s); f.light = 8'(l); f.peak = 8'(p);
    return f;
  endfunction

  // random content; silent frames and zero saturation come up often
  function automatic frame_t rand_frame();
    frame_t f;
    f.hue   = 8'($urandom);
    f.sat   = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom);
    f.light = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
    f.peak  = 8'($urandom);
    return f;
  endfunction

  // tready is stable at the falling edge and matches the next rising edge
  task automatic send_frame(frame_t f);
    logic ok;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= f;
    forever begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
      if (ok) break;
    end
  endtask

  // sender goes quiet until every predicted beat has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_count(logic [23:0] v);
    logic ok;
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    forever begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
      if (ok) break;
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    frame_t dir[$];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase A idling: sender 37 %, receiver 74 %
    send_idle_pct = 37;
    recv_idle_pct = 74;

    // count still zero after reset: the beat is dropped
    send_frame(mk(1, 2, 3, 4));
    settle();

    // all-ones count: sixteen levels, pairs cascade upward
    write_count(24'hFFFFFF);
    dir = '{
      mk(0, 0, 0, 0),       mk(255, 255, 255, 255),  // first silent: copy second
      mk(10, 20, 0, 5),     mk(30, 40, 0, 200),      // both silent: peak only
      mk(200, 100, 50, 7),  mk(1, 1, 0, 9),          // second silent: copy first
      mk(0, 100, 100, 1),   mk(128, 100, 100, 2),    // half turn, taken downward
      mk(250, 0, 10, 3),    mk(5, 0, 20, 4),         // zero saturation, wraps
      mk(100, 255, 255, 0), mk(90, 1, 3, 0),         // negative arc, floor
      mk(255, 255, 255, 255), mk(0, 255, 1, 0),      // extremes
      mk(170, 85, 170, 85), mk(85, 170, 85, 170)
    };
    foreach (dir[i]) send_frame(dir[i]);
    settle();

    // single frame pyramid, then a beat past the count
    write_count(24'd1);
    send_frame(mk(77, 0, 255, 128));
    send_frame(mk(3, 3, 3, 3));
    settle();

    // two levels, end of pyramid reached: unpaired frames fold on themselves
    write_count(24'd257);
    for (int i = 0; i < 257; i++) begin
      if (i == 90) begin
        send_idle_pct = 74;
        recv_idle_pct = 37;
      end
      if (i == 130) settle();          // sender waits for every result
      if (i == 180) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      send_frame(rand_frame());
    end
    send_frame(rand_frame());          // after done: dropped
    settle();

    if (fail_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
design/cfpr_pkg.sv
design/cfpr_pend_mem.sv
design/cfpr_merge.sv
design/colour_frame_pyramid_reducer.sv
test/pyramid_checker.sv
test/tb_top.sv
